// ===== design/ppm_p6_to_rgb222_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// ppm p6 decoder assertion macros
// shared concurrent check templates, clocked on clk, gated by rst_n
// ----------------------------------------------------------------------------
`ifndef PPM_P6_TO_RGB222_DECODER_DEFINES_SVH
`define PPM_P6_TO_RGB222_DECODER_DEFINES_SVH

// same-cycle implication
`define P6DEC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define P6DEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/p6dec_pkg.sv =====
// ----------------------------------------------------------------------------
// p6dec_pkg
// phase codes, byte constants and result type of the ppm p6 decoder
// ----------------------------------------------------------------------------
package p6dec_pkg;

  localparam logic [2:0] PH_HEADER       = 3'd0;
  localparam logic [2:0] PH_AFTER_HEADER = 3'd1;
  localparam logic [2:0] PH_COMMENT      = 3'd2;
  localparam logic [2:0] PH_WIDTH        = 3'd3;
  localparam logic [2:0] PH_HEIGHT       = 3'd4;
  localparam logic [2:0] PH_MAXVAL       = 3'd5;
  localparam logic [2:0] PH_PIXELS       = 3'd6;
  localparam logic [2:0] PH_IDLE         = 3'd7;

  localparam logic [7:0] CHR_P     = 8'h50;
  localparam logic [7:0] CHR_SIX   = 8'h36;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_HASH  = 8'h23;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam int         MAXVAL_8BIT = 255;

  localparam logic [1:0] HDR_LAST_IDX = 2'd2;
  localparam logic [1:0] CHAN_BLUE    = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [5:0] pixel;
    logic       last;
  } p6dec_res_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CHR_P;
      2'd1:    b = CHR_SIX;
      default: b = CHR_LF;
    endcase
    return b;
  endfunction

endpackage

// ===== design/ppm_p6_to_rgb222_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_p6_to_rgb222_decoder
// streams a binary ppm (p6) file in bytes and emits rgb222 pixels
// ----------------------------------------------------------------------------
// usage
//   in_*  : one file byte per word in in_tdata, in_tuser high on the first
//           byte of a file restarts the parser
//   out_* : one rgb222 pixel per word in out_tdata[5:0] (red high),
//           out_tlast high on the final pixel of the image
//   a byte is taken every cycle while in_tready is high; each red/green/blue
//   triple gives one pixel, held in the output register or the skid stage
//   throughput: one byte per cycle while in_tready is high
//   header, comment, size and maxval bytes, bad files, maxval other than
//   255 modulo 2**DIMENSION_BITS and bytes after the image give no words
//   reset: parser waits for "P6\n", output register and skid stage empty
//   stall: a held pixel sits in the output register, one more goes into the
//   skid stage, then in_tready drops until out_tready returns
// ----------------------------------------------------------------------------
`include "ppm_p6_to_rgb222_decoder_defines.svh"

module ppm_p6_to_rgb222_decoder #(
  parameter int DIMENSION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tuser,   // [0] first_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [5:0] pixel, [7:6] zero
  output logic       out_tlast   // last_pixel
);
  import p6dec_pkg::*;

  p6dec_res_t res;
  logic       in_acc;
  logic       out_valid_r;
  logic [5:0] out_pixel_r;
  logic       out_last_r;
  logic       skid_valid_r;
  logic [5:0] skid_pixel_r;
  logic       skid_last_r;
  logic       out_free;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  p6dec_core #(
    .DIMENSION_BITS(DIMENSION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (in_acc),
    .byte_value(in_tdata),
    .first_byte(in_tuser),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_tready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (res.valid) begin
      if (out_free) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_tready) begin
        out_pixel_r <= skid_pixel_r;
        out_last_r  <= skid_last_r;
      end
    end else if (res.valid) begin
      if (out_free) begin
        out_pixel_r <= res.pixel;
        out_last_r  <= res.last;
      end else begin
        skid_pixel_r <= res.pixel;
        skid_last_r  <= res.last;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_pixel_r};
  assign out_tlast  = out_last_r;

  `P6DEC_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r,
                     "skid word held with empty output register")
  `P6DEC_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_tready,
                     out_valid_r && !skid_valid_r, "skid word not moved to output")
  `P6DEC_ASSERT_NEXT(a_pixel_lands, res.valid && !out_valid_r, out_valid_r,
                     "pixel lost on empty output")
  `P6DEC_ASSERT_SAME(a_no_pixel_when_full, skid_valid_r, !res.valid,
                     "pixel produced while skid stage full")

endmodule

// ===== design/p6dec_core.sv =====
// ----------------------------------------------------------------------------
// p6dec_core
// ppm p6 header parser and rgb222 pixel packer, one byte per cycle on byte_vld
// ----------------------------------------------------------------------------
module p6dec_core #(
  parameter int DIMENSION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_vld,
  input  logic [7:0]             byte_value,
  input  logic                   first_byte,
  output p6dec_pkg::p6dec_res_t  res
);
  import p6dec_pkg::*;

  localparam int D = DIMENSION_BITS;

  logic [2:0]   phase_r, phase_nxt, cur_phase;
  logic [1:0]   hdr_idx_r, hdr_idx_nxt, cur_hdr_idx;
  logic [D-1:0] width_r, width_nxt, cur_width;
  logic [D-1:0] height_r, height_nxt, cur_height;
  logic [D-1:0] maxval_r, maxval_nxt, cur_maxval;
  logic [D-1:0] col_r, col_nxt, cur_col;
  logic [D-1:0] row_r, row_nxt, cur_row;
  logic [1:0]   chan_r, chan_nxt, cur_chan;
  logic [5:0]   partial_r, partial_nxt, cur_partial;
  logic [D-1:0] digit_src, digit_val;
  logic [D-1:0] col_inc, row_inc;
  logic [5:0]   packed_colour;

  always_comb begin
    cur_phase   = first_byte ? PH_HEADER : phase_r;
    cur_hdr_idx = first_byte ? '0 : hdr_idx_r;
    cur_width   = first_byte ? '0 : width_r;
    cur_height  = first_byte ? '0 : height_r;
    cur_maxval  = first_byte ? '0 : maxval_r;
    cur_col     = first_byte ? '0 : col_r;
    cur_row     = first_byte ? '0 : row_r;
    cur_chan    = first_byte ? '0 : chan_r;
    cur_partial = first_byte ? '0 : partial_r;
  end

  // value*10 + byte - '0', wrapping
  always_comb begin
    case (cur_phase)
      PH_HEIGHT: digit_src = cur_height;
      PH_MAXVAL: digit_src = cur_maxval;
      default:   digit_src = cur_width;
    endcase
    digit_val = (digit_src << 3) + (digit_src << 1) + D'(byte_value) - D'(CHR_ZERO);
  end

  assign col_inc       = cur_col + D'(1);
  assign row_inc       = cur_row + D'(1);
  assign packed_colour = {cur_partial[3:0], byte_value[7:6]};

  always_comb begin
    phase_nxt   = cur_phase;
    hdr_idx_nxt = cur_hdr_idx;
    width_nxt   = cur_width;
    height_nxt  = cur_height;
    maxval_nxt  = cur_maxval;
    col_nxt     = cur_col;
    row_nxt     = cur_row;
    chan_nxt    = cur_chan;
    partial_nxt = cur_partial;
    res.valid   = 1'b0;
    res.pixel   = packed_colour;
    res.last    = 1'b0;
    case (cur_phase)
      PH_HEADER: begin
        if (cur_hdr_idx > HDR_LAST_IDX || byte_value != magic_byte(cur_hdr_idx)) begin
          phase_nxt = PH_IDLE;
        end else if (cur_hdr_idx == HDR_LAST_IDX) begin
          phase_nxt = PH_AFTER_HEADER;
        end else begin
          hdr_idx_nxt = cur_hdr_idx + 2'd1;
        end
      end
      PH_AFTER_HEADER: begin
        if (byte_value == CHR_HASH) begin
          phase_nxt = PH_COMMENT;
        end else if (byte_value == CHR_SPACE) begin
          phase_nxt = PH_HEIGHT;
        end else begin
          width_nxt = digit_val;
          phase_nxt = PH_WIDTH;
        end
      end
      PH_COMMENT: begin
        if (byte_value == CHR_LF) phase_nxt = PH_AFTER_HEADER;
      end
      PH_WIDTH: begin
        if (byte_value == CHR_SPACE) phase_nxt = PH_HEIGHT;
        else width_nxt = digit_val;
      end
      PH_HEIGHT: begin
        if (byte_value == CHR_LF) phase_nxt = PH_MAXVAL;
        else height_nxt = digit_val;
      end
      PH_MAXVAL: begin
        if (byte_value != CHR_LF) begin
          maxval_nxt = digit_val;
        end else if (cur_maxval == D'(MAXVAL_8BIT) && cur_width != '0 &&
                     cur_height != '0) begin
          phase_nxt   = PH_PIXELS;
          col_nxt     = '0;
          row_nxt     = '0;
          chan_nxt    = '0;
          partial_nxt = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
      PH_PIXELS: begin
        if (cur_chan < CHAN_BLUE) begin
          partial_nxt = packed_colour;
          chan_nxt    = cur_chan + 2'd1;
        end else begin
          res.valid   = 1'b1;
          chan_nxt    = '0;
          partial_nxt = '0;
          col_nxt     = col_inc;
          if (col_inc == cur_width) begin
            col_nxt = '0;
            row_nxt = row_inc;
            if (row_inc == cur_height) begin
              res.last  = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.valid = res.valid & byte_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_idx_r <= '0;
      width_r   <= '0;
      height_r  <= '0;
      maxval_r  <= '0;
      col_r     <= '0;
      row_r     <= '0;
      chan_r    <= '0;
      partial_r <= '0;
    end else if (byte_vld) begin
      phase_r   <= phase_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      maxval_r  <= maxval_nxt;
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      chan_r    <= chan_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

// ===== sim/ppm_p6_to_rgb222_decoder_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppm_p6_to_rgb222_decoder_checker
// watches both stream channels of the ppm p6 decoder, keeps its own copy of
// the parser state, predicts the rgb222 pixel words from every byte taken in
// and compares each pixel word that leaves the block with the oldest one
// ----------------------------------------------------------------------------
module ppm_p6_to_rgb222_decoder_checker #(
  parameter int DIM_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tuser,   // [0] first_byte
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [5:0] pixel, [7:6] zero
  input  logic       out_tlast,  // last_pixel
  output int         fail_count,
  output int         pending,
  output int         pixels_seen
);
  import p6dec_pkg::*;

  localparam int          MAX_REPORTS = 10;
  localparam logic [23:0] MAGIC_SEQ   = {CHR_LF, CHR_SIX, CHR_P};

  typedef struct packed {
    logic [5:0] pixel;
    logic       last;
  } rgb_word_t;

  logic [2:0]          dec_phase;
  logic [1:0]          hdr_idx;
  logic [DIM_BITS-1:0] img_w;
  logic [DIM_BITS-1:0] img_h;
  logic [DIM_BITS-1:0] max_val;
  logic [DIM_BITS-1:0] col_cnt;
  logic [DIM_BITS-1:0] row_cnt;
  logic [1:0]          chan_idx;
  logic [5:0]          part_rgb;
  rgb_word_t           pixel_q[$];

  // decimal accumulate, any byte counts as a digit, wraps at DIM_BITS
  function automatic logic [DIM_BITS-1:0] shift_in_digit(input logic [DIM_BITS-1:0] acc,
                                                         input logic [7:0] b);
    return DIM_BITS'(acc * 10 + b - CHR_ZERO);
  endfunction

  task automatic clear_parser();
    dec_phase = PH_HEADER;
    hdr_idx   = '0;
    img_w     = '0;
    img_h     = '0;
    max_val   = '0;
    col_cnt   = '0;
    row_cnt   = '0;
    chan_idx  = '0;
    part_rgb  = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic restart);
    logic [5:0] rgb;
    rgb_word_t  w;
    if (restart) clear_parser();
    case (dec_phase)
      PH_HEADER: begin
        if (hdr_idx > HDR_LAST_IDX || b != MAGIC_SEQ[8*hdr_idx +: 8]) dec_phase = PH_IDLE;
        else if (hdr_idx == HDR_LAST_IDX) dec_phase = PH_AFTER_HEADER;
        else hdr_idx = hdr_idx + 2'd1;
      end
      PH_AFTER_HEADER: begin
        if (b == CHR_HASH) dec_phase = PH_COMMENT;
        else if (b == CHR_SPACE) dec_phase = PH_HEIGHT;
        else begin
          img_w     = shift_in_digit(img_w, b);
          dec_phase = PH_WIDTH;
        end
      end
      PH_COMMENT: begin
        if (b == CHR_LF) dec_phase = PH_AFTER_HEADER;
      end
      PH_WIDTH: begin
        if (b == CHR_SPACE) dec_phase = PH_HEIGHT;
        else img_w = shift_in_digit(img_w, b);
      end
      PH_HEIGHT: begin
        if (b == CHR_LF) dec_phase = PH_MAXVAL;
        else img_h = shift_in_digit(img_h, b);
      end
      PH_MAXVAL: begin
        if (b != CHR_LF) max_val = shift_in_digit(max_val, b);
        else if (max_val == DIM_BITS'(MAXVAL_8BIT) && img_w != '0 && img_h != '0) begin
          dec_phase = PH_PIXELS;
          col_cnt   = '0;
          row_cnt   = '0;
          chan_idx  = '0;
          part_rgb  = '0;
        end else begin
          dec_phase = PH_IDLE;
        end
      end
      PH_PIXELS: begin
        rgb = {part_rgb[3:0], b[7:6]};
        if (chan_idx != CHAN_BLUE) begin
          part_rgb = rgb;
          chan_idx = chan_idx + 2'd1;
        end else begin
          chan_idx = '0;
          part_rgb = '0;
          w.pixel  = rgb;
          w.last   = 1'b0;
          col_cnt  = col_cnt + 1'b1;
          if (col_cnt == img_w) begin
            col_cnt = '0;
            row_cnt = row_cnt + 1'b1;
            if (row_cnt == img_h) begin
              w.last    = 1'b1;
              dec_phase = PH_IDLE;
            end
          end
          pixel_q.push_back(w);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rgb_word_t want;
    if (!rst_n) begin
      clear_parser();
      pixel_q.delete();
      fail_count  = 0;
      pending     = 0;
      pixels_seen = 0;
    end else begin
      // a pixel word is registered before it leaves, so check before predicting
      if (out_tvalid && out_tready) begin
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t unexpected pixel word: tdata %02h tlast %0b",
                     $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (out_tdata !== {2'b00, want.pixel} || out_tlast !== want.last) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t pixel word mismatch: expected tdata %02h tlast %0b, got %02h %0b",
                       $time, {2'b00, want.pixel}, want.last, out_tdata, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tuser);
      pending = pixel_q.size();
    end
  end

endmodule

// ===== sim/ppm_p6_to_rgb222_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppm_p6_to_rgb222_decoder_tb
// streams short binary ppm files into the decoder: a few fixed files, then
// random well-formed images mixed with bad headers, odd maxvals, empty,
// zero and wrapping sizes, truncated files and noise, with random stalls on
// both channels; the checker predicts and compares every pixel word
// ----------------------------------------------------------------------------
module ppm_p6_to_rgb222_decoder_tb;
  import p6dec_pkg::*;

  localparam int DIM_BITS       = 16;
  localparam int ITEMS          = 1200;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum int {
    FK_GOOD,
    FK_BAD_MAGIC,
    FK_MAXVAL,
    FK_ZERO_DIM,
    FK_WRAP,
    FK_TRUNC,
    FK_NOISE,
    FK_JUNK_DIGIT
  } file_kind_e;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] byte_value
  logic       in_tuser;   // [0] first_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [5:0] pixel, [7:6] zero
  logic       out_tlast;  // last_pixel

  int chk_fails;
  int chk_pending;
  int chk_pixels;

  int unsigned bytes_sent;
  int unsigned files_sent;
  int unsigned good_files;
  int unsigned stall_cnt;
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          long_hold    = 1'b0;
  bit          start_flag;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ppm_p6_to_rgb222_decoder #(
    .DIMENSION_BITS(DIM_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  ppm_p6_to_rgb222_decoder_checker #(
    .DIM_BITS(DIM_BITS)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (chk_fails),
    .pending    (chk_pending),
    .pixels_seen(chk_pixels)
  );

  // one file byte per word, first word of a file carries the restart flag
  task automatic put(input logic [7:0] b);
    int unsigned gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start_flag;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    start_flag = 1'b0;
    bytes_sent++;
  endtask

  task automatic put_dec(input int unsigned v);
    logic [7:0]  digs[$];
    int unsigned r;
    r = v;
    do begin
      digs.push_front(8'(CHR_ZERO + r % 10));
      r = r / 10;
    end while (r != 0);
    foreach (digs[i]) put(digs[i]);
  endtask

  task automatic send_file(input file_kind_e kind, input int unsigned force_w);
    int unsigned w, h, mv, eff_w, n, ncom, clen, k;
    logic [7:0]  b;
    bit          empty_w, empty_h;
    start_flag = 1'b1;
    files_sent++;
    empty_w = 1'b0;
    empty_h = 1'b0;
    w  = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
    if (force_w != 0) w = force_w;
    h  = $urandom_range(1, 4);
    mv = MAXVAL_8BIT;
    case (kind)
      FK_NOISE: begin
        start_flag = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      end
      FK_BAD_MAGIC: begin
        k = $urandom_range(0, 2);
        for (int i = 0; i < k; i++) put(i == 0 ? CHR_P : CHR_SIX);
        do b = 8'($urandom_range(0, 255));
        while (b == (k == 0 ? CHR_P : (k == 1 ? CHR_SIX : CHR_LF)));
        put(b);
        repeat ($urandom_range(0, 6)) put(8'($urandom_range(0, 255)));
      end
      default: begin
        if (kind == FK_MAXVAL) begin
          case ($urandom_range(0, 5))
            0:       mv = 0;
            1:       mv = 254;
            2:       mv = 256;
            3:       mv = 65535;
            4:       mv = 65536 + MAXVAL_8BIT;
            default: mv = $urandom_range(0, 999);
          endcase
        end
        if (kind == FK_WRAP) w = 65536 + $urandom_range(0, 3);
        if (kind == FK_ZERO_DIM) begin
          case ($urandom_range(0, 3))
            0:       w = 0;
            1:       h = 0;
            2:       begin w = 0; empty_w = 1'b1; end
            default: begin h = 0; empty_h = 1'b1; end
          endcase
        end
        put(CHR_P);
        put(CHR_SIX);
        put(CHR_LF);
        ncom = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        repeat (ncom) begin
          put(CHR_HASH);
          clen = $urandom_range(0, 5);
          repeat (clen) begin
            do b = 8'($urandom_range(0, 255)); while (b == CHR_LF);
            put(b);
          end
          put(CHR_LF);
        end
        eff_w = w % 65536;
        if (!empty_w) put_dec(w);
        if (kind == FK_JUNK_DIGIT) begin
          do b = 8'($urandom_range(0, 255)); while (b == CHR_SPACE);
          put(b);
          eff_w = (eff_w * 10 + b + 65536 - CHR_ZERO) % 65536;
        end
        put(CHR_SPACE);
        if (!empty_h) put_dec(h);
        put(CHR_LF);
        put_dec(mv);
        put(CHR_LF);
        if (eff_w != 0 && h != 0 && mv % 65536 == MAXVAL_8BIT) n = eff_w * h * 3;
        else n = $urandom_range(0, 6);
        if (n > 600) n = $urandom_range(3, 30);
        if (kind == FK_TRUNC && n > 1) n = $urandom_range(1, n - 1);
        repeat (n) put(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
        if (kind == FK_GOOD) good_files++;
      end
    endcase
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 6) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  initial begin
    stall_cnt = 0;
    while (stall_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && !(in_tvalid && in_tready) && !(out_tvalid && out_tready)) stall_cnt++;
      else stall_cnt = 0;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    file_kind_e kind;
    bytes_sent = 0;
    files_sent = 0;
    good_files = 0;
    start_flag = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 1x1 image without a restart flag, extreme channel bytes, one trailing byte
    put(CHR_P); put(CHR_SIX); put(CHR_LF);
    put(8'h31); put(CHR_SPACE); put(8'h31); put(CHR_LF);
    put(8'h32); put(8'h35); put(8'h35); put(CHR_LF);
    put(8'hff); put(8'h3f); put(8'hc0);
    put(8'h00);
    // bad first header byte
    start_flag = 1'b1;
    put(8'h51);
    // empty width, straight to the height
    start_flag = 1'b1;
    put(CHR_P); put(CHR_SIX); put(CHR_LF); put(CHR_SPACE); put(8'h31); put(CHR_LF);
    put(8'h32); put(8'h35); put(8'h35); put(CHR_LF);
    files_sent = 3;
    good_files = 1;

    while (bytes_sent < ITEMS) begin
      if (bytes_sent > ITEMS * 4 / 5) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      if (files_sent == 5) begin
        long_hold = 1'b1;
        send_file(FK_GOOD, 6);
      end else begin
        if (src_idle_on && files_sent % 10 == 9) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (chk_pending != 0);
        end
        case ($urandom_range(0, 19))
          12:      kind = FK_BAD_MAGIC;
          13:      kind = FK_MAXVAL;
          14:      kind = FK_ZERO_DIM;
          15:      kind = FK_WRAP;
          16:      kind = FK_TRUNC;
          17:      kind = FK_NOISE;
          18:      kind = FK_JUNK_DIGIT;
          default: kind = FK_GOOD;
        endcase
        send_file(kind, 0);
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (chk_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run sent %0d bytes in %0d files (%0d well-formed), %0d pixel words compared",
             bytes_sent, files_sent, good_files, chk_pixels);
    $display("with restarts, broken headers, odd maxvals, zero/empty/wrapped sizes and stalls");
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (chk_pending != 0) $display("%0d predicted pixel words never came out", chk_pending);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/p6dec_pkg.sv
design/p6dec_core.sv
design/ppm_p6_to_rgb222_decoder.sv
sim/ppm_p6_to_rgb222_decoder_checker.sv
sim/ppm_p6_to_rgb222_decoder_tb.sv
